// ===== sv/gbfs_pkg.sv =====
// Shared types, constants and register codes for the grid BFS block.
package gbfs_pkg;

  localparam int unsigned GridMaxDef = 8;
  localparam int unsigned RoomW      = 9;
  localparam int unsigned LenW       = 9;
  localparam logic [LenW-1:0] LenMax = '1;

  // Register codes (word index on the config port)
  localparam logic [1:0] RegGridEdge = 2'd0;
  localparam logic [1:0] RegStart    = 2'd1;
  localparam logic [1:0] RegExit     = 2'd2;

  // Input operations
  localparam logic OpLoad  = 1'b0;
  localparam logic OpSolve = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [RoomW-1:0] room_index;
    logic             room_present;
    logic [5:0]       door_mask;
  } in_beat_t;

  typedef struct packed {
    logic            found;
    logic [LenW-1:0] path_length;
  } out_beat_t;

endpackage

// ===== sv/grid_bfs_shortest_path.sv =====
// Top level: config registers, BFS sequencer, queue memory and result register.
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_ready_o | in_beat_t
//  out     | out | out_valid_o/out_ready_i | out_beat_t
//  cfg     | in  | APB psel/penable       | 32-bit words
// A load beat is taken back to back while idle. A search clears
// the visited map, seeds the queue, then reads each dequeued room's queue entry
// and room word; a present room finds its coordinates by repeated subtraction,
// then checks each door in turn, reading the neighbour behind an open in-grid
// door and queueing it if present and unseen. It stops when the exit is dequeued
// or the queue runs empty. An unset or outside end goes straight to the result.
// After reset the room store and visited map are cleared one entry per cycle
// (no input accepted). A stalled result blocks input.
module grid_bfs_shortest_path
  import gbfs_pkg::*;
#(
  parameter int unsigned GridMax = GridMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gbfs_pkg::in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gbfs_pkg::out_beat_t out_data_o,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);
  localparam int unsigned Cells = GridMax*GridMax*GridMax;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned CW    = $clog2(GridMax+1);
  localparam int unsigned QW    = AddrW + 1;

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_VCLR = 12'b000000000100,
    S_INIT = 12'b000000001000,
    S_DEQ  = 12'b000000010000,
    S_QRD  = 12'b000000100000,
    S_CUR  = 12'b000001000000,
    S_DIV  = 12'b000010000000,
    S_NB   = 12'b000100000000,
    S_NRD  = 12'b001000000000,
    S_NCHK = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  // ---------------- config registers
  logic [3:0] edge_q;
  logic [9:0] start_q, exit_q;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= 4'd8;
      start_q <= '1;
      exit_q  <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegGridEdge: edge_q  <= pwdata[3:0];
        RegStart:    start_q <= pwdata[9:0];
        RegExit:     exit_q  <= pwdata[9:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegGridEdge: prdata = {28'd0, edge_q};
      RegStart:    prdata = {22'd0, start_q};
      RegExit:     prdata = {22'd0, exit_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- state
  state_e           st_q, st_d;
  logic [QW-1:0]    head_q, tail_q, clr_q;
  logic [CW-1:0]    n_q;
  logic [AddrW-1:0] cur_q, tgt_q, nb_q, rem_q;
  logic [CW-1:0]    x_q, y_q, z_q;
  logic [LenW-1:0]  dep_q;
  logic [5:0]       doors_q;
  logic [2:0]       dir_q;
  logic             out_v_q;
  out_beat_t        res_q;

  // store port
  logic             st_we;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [6:0]       st_wdata, st_rdata;

  gbfs_store #(.GridMax(GridMax), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  // visited memory and queue memory (entry + depth)
  logic                   vis_mem [Cells];
  logic                   vis_rd_q;
  logic [AddrW+LenW-1:0]  q_mem [Cells];
  logic [AddrW+LenW-1:0]  q_rd_q;
  logic                   vis_we, q_we;
  logic [AddrW-1:0]       vis_addr;

  assign in_ready_o  = (st_q == S_IDLE) && !(out_v_q && !out_ready_i);
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_o;

  // coordinate step of the current room toward door dir_q
  logic             nb_ok;
  logic [AddrW-1:0] nb_idx;
  logic [2*CW-1:0]  nn;
  always_comb begin
    nn = n_q * n_q;
    nb_ok  = 1'b0;
    nb_idx = cur_q;
    case (dir_q)
      3'd0: begin nb_ok = ({1'b0,x_q} + 1'b1) < {1'b0,n_q}; nb_idx = cur_q + 1'b1; end
      3'd1: begin nb_ok = x_q != '0; nb_idx = cur_q - 1'b1; end
      3'd2: begin nb_ok = ({1'b0,y_q} + 1'b1) < {1'b0,n_q};
                  nb_idx = cur_q + AddrW'(n_q); end
      3'd3: begin nb_ok = y_q != '0; nb_idx = cur_q - AddrW'(n_q); end
      3'd4: begin nb_ok = ({1'b0,z_q} + 1'b1) < {1'b0,n_q};
                  nb_idx = cur_q + AddrW'(nn); end
      3'd5: begin nb_ok = z_q != '0; nb_idx = cur_q - AddrW'(nn); end
      default: ;
    endcase
  end

  // clamped edge and cell count
  logic [CW-1:0] n_cl;
  logic [3*CW-1:0] cells_cl;
  always_comb begin
    if (edge_q == 4'd0) n_cl = CW'(1);
    else if (32'(edge_q) > GridMax) n_cl = CW'(GridMax);
    else n_cl = CW'(edge_q);
    cells_cl = n_cl * n_cl * n_cl;
  end

  // memory access steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = in_data_i.room_index[AddrW-1:0];
    st_wdata = {in_data_i.room_present, in_data_i.door_mask};
    st_raddr = cur_q;
    vis_we   = 1'b0;
    vis_addr = nb_q;
    q_we     = 1'b0;
    if (st_q == S_CLR) begin
      st_we = 1'b1; st_waddr = clr_q[AddrW-1:0]; st_wdata = '0;
      vis_we = 1'b1; vis_addr = clr_q[AddrW-1:0];
    end else if (st_q == S_VCLR) begin
      vis_we = 1'b1; vis_addr = clr_q[AddrW-1:0];
    end else if (in_acc && in_data_i.operation == OpLoad &&
                 32'(in_data_i.room_index) < Cells) begin
      st_we = 1'b1;
    end
    if (st_q == S_QRD) st_raddr = q_rd_q[AddrW+LenW-1:LenW];
    if (st_q == S_NB) st_raddr = nb_idx;
    if (st_q == S_NRD) st_raddr = nb_q;
    if (st_q == S_INIT) begin
      vis_we = 1'b1; vis_addr = start_q[AddrW-1:0]; q_we = 1'b1;
    end
    if (st_q == S_NB) vis_addr = nb_idx;
    if (st_q == S_NCHK && st_rdata[6] && !vis_rd_q &&
        32'(tail_q) < Cells) begin
      vis_we = 1'b1; q_we = 1'b1;
    end
  end

  logic [AddrW+LenW-1:0] q_wdata;
  assign q_wdata = (st_q == S_INIT) ? {start_q[AddrW-1:0], {LenW{1'b0}}}
                                    : {nb_q, dep_q + 1'b1};

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_addr] <= !(st_q == S_CLR || st_q == S_VCLR);
    vis_rd_q <= vis_mem[vis_addr];
    if (q_we) q_mem[tail_q[AddrW-1:0]] <= q_wdata;
    q_rd_q <= q_mem[head_q[AddrW-1:0]];
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLR:  if (clr_q == QW'(Cells - 1)) st_d = S_IDLE;
      S_IDLE: if (in_acc && in_data_i.operation == OpSolve) begin
        if (start_q[9] || exit_q[9] || 32'(start_q) >= 32'(cells_cl) ||
            32'(exit_q) >= 32'(cells_cl)) st_d = S_DONE;
        else st_d = S_VCLR;
      end
      S_VCLR: if (clr_q == QW'(Cells - 1)) st_d = S_INIT;
      S_INIT: st_d = S_DEQ;
      S_DEQ:  st_d = (head_q < tail_q) ? S_QRD : S_DONE;
      S_QRD:  st_d = S_CUR;
      S_CUR:  st_d = (cur_q == tgt_q) ? S_DONE : (st_rdata[6] ? S_DIV : S_DEQ);
      S_DIV:  if (rem_q < AddrW'(n_q)) st_d = S_NB;
      S_NB: begin
        if (dir_q == 3'd6) st_d = S_DEQ;
        else if (doors_q[dir_q] && nb_ok) st_d = S_NRD;
      end
      S_NRD:  st_d = S_NCHK;
      S_NCHK: st_d = S_NB;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  logic found_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; head_q <= '0; tail_q <= '0;
      out_v_q <= 1'b0; found_q <= 1'b0; dir_q <= '0;
    end else begin
      st_q <= st_d;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (st_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          found_q <= 1'b0;
          n_q     <= n_cl;
          tgt_q   <= exit_q[AddrW-1:0];
          if (st_d == S_VCLR) begin
            clr_q  <= '0;
            head_q <= '0;
            tail_q <= '0;
          end
        end
        S_VCLR: clr_q <= clr_q + 1'b1;
        S_INIT: tail_q <= QW'(1);
        S_QRD: begin
          {cur_q, dep_q} <= q_rd_q;
          head_q <= head_q + 1'b1;
        end
        S_CUR: begin
          if (cur_q == tgt_q) found_q <= 1'b1;
          doors_q <= st_rdata[5:0];
          dir_q   <= '0;
        end
        S_NB: begin
          nb_q <= nb_idx;
          if (!(doors_q[dir_q] && nb_ok) && dir_q != 3'd6) dir_q <= dir_q + 1'b1;
        end
        S_NCHK: begin
          if (q_we) tail_q <= tail_q + 1'b1;
          dir_q <= dir_q + 1'b1;
        end
        S_DONE: begin
          out_v_q <= 1'b1;
          res_q.found <= found_q;
          res_q.path_length <= found_q ? dep_q : '0;
        end
        default: ;
      endcase
    end
  end

  // x,y,z of the current room by repeated subtraction of edge^2, then edge
  always_ff @(posedge clk_i) begin
    if (st_q == S_CUR) begin
      rem_q <= cur_q;
      x_q   <= '0;
      y_q   <= '0;
      z_q   <= '0;
    end else if (st_q == S_DIV) begin
      if (rem_q >= AddrW'(nn)) begin
        rem_q <= rem_q - AddrW'(nn);
        z_q   <= z_q + 1'b1;
      end else if (rem_q >= AddrW'(n_q)) begin
        rem_q <= rem_q - AddrW'(n_q);
        y_q   <= y_q + 1'b1;
      end else begin
        x_q <= CW'(rem_q);
      end
    end
  end
endmodule

// ===== sv/gbfs_store.sv =====
// Room word store: one 7-bit word (present bit and door mask) per cell.
module gbfs_store #(
  parameter int unsigned GridMax = gbfs_pkg::GridMaxDef,
  parameter int unsigned AddrW   = $clog2(GridMax*GridMax*GridMax)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [6:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [6:0]       rdata_o
);
  import gbfs_pkg::*;
  localparam int unsigned Cells = GridMax*GridMax*GridMax;

  logic [6:0] mem_q [Cells];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/gbfs_checker.sv =====
// Port-level checker for the grid BFS block, bound to the top level.
module gbfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [9:0] out_data_o
);
  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  // not-found results carry zero length
  a_nf_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o[9] |-> out_data_o[8:0] == 9'd0)
    else $error("length without found");
  // a stalled result blocks input
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
endmodule

bind grid_bfs_shortest_path gbfs_checker u_gbfs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_data_o(out_data_o)
);

// ===== sim/grid_bfs_shortest_path_test.sv =====
// Testbench for the grid BFS block: directed and random room loads and searches.
module grid_bfs_shortest_path_test;
  import gbfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreCells = GridMaxDef * GridMaxDef * GridMaxDef;
  localparam int unsigned IdleLimit  = 200000;
  localparam int unsigned RandItems  = 1650;

  // Tracks the room store and registers, predicts each search outcome.
  class path_scoreboard;
    logic [6:0]        rooms[StoreCells];
    logic [3:0]        edge_reg;
    logic signed [9:0] start_reg;
    logic signed [9:0] exit_reg;
    out_beat_t         pending_paths[$];
    int                mismatches;
    int                loads;
    int                searches;
    int                reached;

    function new();
      foreach (rooms[i]) rooms[i] = '0;
      edge_reg   = 4'd8;
      start_reg  = -10'sd1;
      exit_reg   = -10'sd1;
      mismatches = 0;
      loads      = 0;
      searches   = 0;
      reached    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegGridEdge: edge_reg  = val[3:0];
        RegStart:    start_reg = val[9:0];
        RegExit:     exit_reg  = val[9:0];
        default: ;
      endcase
    endfunction

    // Breadth-first walk with the same clamping and early exit as the block
    function out_beat_t shortest_path();
      out_beat_t res;
      int        n;
      int        cells;
      int        s;
      int        t;
      int        cur;
      int        dep;
      int        x;
      int        y;
      int        z;
      int        nb;
      bit        seen[StoreCells];
      int        room_q[$];
      int        depth_q[$];
      res = '0;
      n = (edge_reg == 0) ? 1 : (edge_reg > GridMaxDef) ? GridMaxDef : int'(edge_reg);
      cells = n * n * n;
      s = start_reg;
      t = exit_reg;
      if (s < 0 || t < 0 || s >= cells || t >= cells) return res;
      foreach (seen[i]) seen[i] = 1'b0;
      room_q.push_back(s);
      depth_q.push_back(0);
      seen[s] = 1'b1;
      while (room_q.size() > 0) begin
        cur = room_q.pop_front();
        dep = depth_q.pop_front();
        if (cur == t) begin
          res.found = 1'b1;
          res.path_length = (dep > int'(LenMax)) ? LenMax : dep[LenW-1:0];
          return res;
        end
        if (!rooms[cur][6]) continue;
        for (int d = 0; d < 6; d++) begin
          if (!rooms[cur][d]) continue;
          x = cur % n;
          y = (cur / n) % n;
          z = cur / (n * n);
          case (d)
            0: x++;
            1: x--;
            2: y++;
            3: y--;
            4: z++;
            default: z--;
          endcase
          if (x < 0 || x >= n || y < 0 || y >= n || z < 0 || z >= n) continue;
          nb = x + y * n + z * n * n;
          if (!rooms[nb][6] || seen[nb]) continue;
          seen[nb] = 1'b1;
          room_q.push_back(nb);
          depth_q.push_back(dep + 1);
        end
      end
      return res;
    endfunction

    function void note_beat(in_beat_t b);
      if (b.operation == OpLoad) begin
        loads++;
        if (b.room_index < StoreCells) rooms[b.room_index] = {b.room_present, b.door_mask};
      end else begin
        searches++;
        pending_paths.push_back(shortest_path());
      end
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (pending_paths.size() == 0) begin
        report("unexpected result beat, found", got.found, 0);
        return;
      end
      want = pending_paths.pop_front();
      if (want.found) reached++;
      if (got.found !== want.found) report("found", got.found, want.found);
      if (got.path_length !== want.path_length)
        report("path_length", got.path_length, want.path_length);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  path_scoreboard paths = new();
  bit          no_idle;
  bit          hold_req;
  int          idle_cycles;

  grid_bfs_shortest_path dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Monitor both channels and the watchdog
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) paths.note_beat(in_data_i);
    if (out_valid_o && out_ready_i) paths.check_beat(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired with %0d results outstanding",
               paths.pending_paths.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, calm stretches, one long hold-off on request
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) stall = $urandom_range(15, 60);
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_room(int idx, bit present, logic [5:0] doors);
    in_beat_t b;
    b = '0;
    b.operation    = OpLoad;
    b.room_index   = idx[RoomW-1:0];
    b.room_present = present;
    b.door_mask    = doors;
    send_beat(b);
  endtask

  task automatic run_search();
    in_beat_t b;
    b = '0;
    b.operation  = OpSolve;
    b.room_index = RoomW'($urandom());
    b.door_mask  = 6'($urandom());
    b.room_present = 1'($urandom());
    send_beat(b);
  endtask

  // Let the block drain before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (paths.pending_paths.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Two-phase register write; pready is tied high
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    paths.write_reg(idx, val);
  endtask

  task automatic set_ends(int s, int t);
    cfg_write(RegStart, {22'd0, s[9:0]});
    cfg_write(RegExit, {22'd0, t[9:0]});
  endtask

  // Start/exit picker: mostly inside the grid, sometimes unset or outside
  function automatic int pick_end(int cells);
    case ($urandom_range(0, 19))
      0: return -1;
      1: return -$urandom_range(2, 512);
      2: return $urandom_range(cells, 511);
      default: return $urandom_range(0, cells - 1);
    endcase
  endfunction

  initial begin
    int items;
    int n;
    int cells;
    int nloads;
    int edge_val;
    no_idle = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unset ends, start equals exit on an absent room
    run_search();
    wait_idle();
    set_ends(5, 5);
    run_search();
    wait_idle();
    // Fully open 2x2x2 cube, corner to corner, plus top-index load
    cfg_write(RegGridEdge, 32'd2);
    set_ends(0, 7);
    for (int i = 0; i < 8; i++) load_room(i, 1'b1, 6'h3f);
    load_room(511, 1'b1, 6'h00);
    run_search();
    // Absent start room follows no doors
    load_room(0, 1'b0, 6'h3f);
    run_search();
    wait_idle();
    // Exit just outside the grid
    set_ends(1, 8);
    run_search();
    wait_idle();
    // Zero edge clamps to one cell
    cfg_write(RegGridEdge, 32'd0);
    set_ends(0, 0);
    run_search();
    wait_idle();
    // Oversized edge clamps to the largest grid; far corner unreachable
    cfg_write(RegGridEdge, 32'd15);
    set_ends(0, 511);
    run_search();
    wait_idle();
    // Most negative start
    set_ends(-512, 3);
    run_search();
    wait_idle();

    // Random phases: new grid, fill it, then several searches
    while (items < RandItems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 19))
        0:       edge_val = 0;
        1:       edge_val = $urandom_range(9, 15);
        2, 3:    edge_val = 8;
        4, 5:    edge_val = $urandom_range(5, 7);
        default: edge_val = $urandom_range(1, 4);
      endcase
      n = (edge_val == 0) ? 1 : (edge_val > 8) ? 8 : edge_val;
      cells = n * n * n;
      cfg_write(RegGridEdge, edge_val);
      nloads = (cells <= 64) ? cells : 80;
      for (int i = 0; i < nloads; i++) begin
        load_room((cells <= 64) ? i : $urandom_range(0, cells - 1),
                  $urandom_range(0, 6) != 0, 6'(~($urandom() & $urandom())));
        items++;
      end
      // Stray loads anywhere in the store, any bits
      repeat ($urandom_range(0, 2)) begin
        load_room($urandom_range(0, 511), 1'($urandom()), 6'($urandom()));
        items++;
      end
      repeat ($urandom_range(1, 4)) begin
        wait_idle();
        set_ends(pick_end(cells), pick_end(cells));
        repeat ($urandom_range(1, 3)) begin
          run_search();
          items++;
        end
      end
      wait_idle();
    end

    // Back-pressure: receiver holds off while searches keep coming
    no_idle = 1'b1;
    cfg_write(RegGridEdge, 32'd2);
    set_ends(0, 1);
    hold_req = 1'b1;
    repeat (12) run_search();
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d room loads and %0d searches, %0d reached the exit",
             paths.loads, paths.searches, paths.reached);
    $display("Grid edges 0 to 15, unset and out-of-range ends, long receiver hold-off");
    if (paths.mismatches == 0 && paths.pending_paths.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gbfs_pkg.sv
sv/gbfs_store.sv
sv/grid_bfs_shortest_path.sv
sv/gbfs_checker.sv
sim/grid_bfs_shortest_path_test.sv
